[design/rgb_led_effect_sequencer_core_defines.svh]
// Assertion macros shared by the LED effect sequencer RTL.
// No dependencies; the assertions compile out when SYNTH is defined.
`ifndef RGB_LED_EFFECT_SEQUENCER_CORE_DEFINES_SVH
`define RGB_LED_EFFECT_SEQUENCER_CORE_DEFINES_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define RLES_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A consequent that must hold in the same cycle as its antecedent.
`define RLES_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define RLES_ASSERT(lbl, clk, rst, prop, msg)
`define RLES_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[design/rles_pkg.sv]
// Types, codes and helper functions of the LED effect sequencer.
// No dependencies; used by every RTL module of the block.
package rles_pkg;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_PAL_WRITE = 3'd1,
      CMD_SEQ_WRITE = 3'd2,
      CMD_PAL_SWAP  = 3'd3,
      CMD_START     = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_OFF      = 3'd0,
      MODE_ON       = 3'd1,
      MODE_BREATH   = 3'd2,
      MODE_FADE     = 3'd3,
      MODE_BLINK    = 3'd4,
      MODE_RELEASED = 3'd5
   } mode_type;

   localparam logic CSR_STEP_SIZE = 1'b0;
   localparam logic CSR_DELAY_MS  = 1'b1;

   localparam logic [7:0]  STEP_SIZE_RESET = 8'd5;
   localparam logic [15:0] DELAY_MS_RESET  = 16'd30;
   localparam logic [7:0]  CHANNEL_MAX     = 8'd255;

   localparam int unsigned TICK_W   = 17;
   localparam logic [16:0] TICK_MAX = 17'h1FFFF;

   // Palette read ports: current target, next target, sequence entry 0,
   // and the two entries of a swap.
   localparam int unsigned PAL_RD_PORTS = 5;
   localparam int unsigned PRD_CUR      = 0;
   localparam int unsigned PRD_NEXT     = 1;
   localparam int unsigned PRD_FIRST    = 2;
   localparam int unsigned PRD_SWAP_A   = 3;
   localparam int unsigned PRD_SWAP_B   = 4;

   // Sequence read ports: cursor, next cursor, entry 0.
   localparam int unsigned SEQ_RD_PORTS = 3;
   localparam int unsigned SRD_CUR      = 0;
   localparam int unsigned SRD_NEXT     = 1;
   localparam int unsigned SRD_FIRST    = 2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   localparam color_type COLOR_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
   localparam color_type COLOR_WHITE = '{red: CHANNEL_MAX, green: CHANNEL_MAX,
                                         blue: CHANNEL_MAX};

   typedef struct packed {
      logic       en_a;
      logic [3:0] addr_a;
      color_type  color_a;
      logic       en_b;
      logic [3:0] addr_b;
      color_type  color_b;
   } pal_wr_type;

   typedef struct packed {
      logic       en;
      logic [3:0] pos;
      logic [3:0] value;
   } seq_wr_type;

   // Moves one channel by step toward tgt, landing on tgt when within step.
   function automatic logic [7:0] approach(input logic [7:0] cur,
                                           input logic [7:0] tgt,
                                           input logic [7:0] step);
      logic [7:0] diff;
      if (cur >= tgt) begin
         diff = cur - tgt;
         approach = (diff <= step) ? tgt : cur - step;
      end else begin
         diff = tgt - cur;
         approach = (diff <= step) ? tgt : cur + step;
      end
   endfunction

   function automatic color_type step_color(input color_type cur,
                                            input color_type tgt,
                                            input logic [7:0] step);
      color_type res;
      res.red   = approach(cur.red, tgt.red, step);
      res.green = approach(cur.green, tgt.green, step);
      res.blue  = approach(cur.blue, tgt.blue, step);
      step_color = res;
   endfunction

endpackage

[design/rgb_led_effect_sequencer_core.sv]
// A request is captured in the input register, passes the compute stage and
// has its response registered in the response register, which drives rsp_valid.
// Throughput: one request per cycle while rsp_ready stays high; the single
// compute stage between the input register and the response register sets that figure.
// Reset (synchronous, active high) restores the palette (entry 0 white), the
// sequence, the mode, the counters and both configuration registers at once.
module rgb_led_effect_sequencer_core #(
   parameter int PALETTE_DEPTH = 16,
   parameter int SEQ_DEPTH     = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_palette_index,
   input  logic [3:0]  req_second_index,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [3:0]  req_seq_position,
   input  logic [2:0]  req_mode_in,
   input  logic [4:0]  req_seq_length,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_led_owned,
   output logic        rsp_color_changed,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

`include "rgb_led_effect_sequencer_core_defines.svh"

   // Cursor width follows the sequence depth; the length register must also
   // hold the depth itself.
   localparam int SEQ_AW = $clog2(SEQ_DEPTH);
   localparam int SEQ_CW = $clog2(SEQ_DEPTH + 1);

   // ---------------------------------------------------------------------
   // Configuration registers. The port never stalls a write.
   // ---------------------------------------------------------------------
   logic [7:0]  step_size_ff;
   logic [15:0] delay_ms_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= rles_pkg::STEP_SIZE_RESET;
         delay_ms_ff  <= rles_pkg::DELAY_MS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rles_pkg::CSR_STEP_SIZE: begin
               step_size_ff <= csr_wdata[7:0];
            end
            rles_pkg::CSR_DELAY_MS: begin
               delay_ms_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register. A request is captured here and processed once the
   // response register is free or being emptied.
   // ---------------------------------------------------------------------
   logic       hold_valid_ff;
   logic [2:0] hold_cmd_ff;
   logic [3:0] hold_pi_ff;
   logic [3:0] hold_si_ff;
   logic [7:0] hold_red_ff;
   logic [7:0] hold_green_ff;
   logic [7:0] hold_blue_ff;
   logic [3:0] hold_pos_ff;
   logic [2:0] hold_mode_ff;
   logic [4:0] hold_len_ff;
   logic       hold_valid_in;
   logic       req_take;
   logic       fire;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // The compute stage fires when it holds a request and the response
   // register is empty or is handed over in this same cycle.
   assign fire          = hold_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready     = ~hold_valid_ff | fire;
   assign req_take      = req_valid & req_ready;
   assign hold_valid_in = req_take | (hold_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_cmd_ff   <= req_cmd;
         hold_pi_ff    <= req_palette_index;
         hold_si_ff    <= req_second_index;
         hold_red_ff   <= req_red_in;
         hold_green_ff <= req_green_in;
         hold_blue_ff  <= req_blue_in;
         hold_pos_ff   <= req_seq_position;
         hold_mode_ff  <= req_mode_in;
         hold_len_ff   <= req_seq_length;
      end
   end

   // ---------------------------------------------------------------------
   // Effect state.
   // ---------------------------------------------------------------------
   rles_pkg::mode_type  effect_mode_ff, effect_mode_in;
   logic [16:0]         tick_count_ff, tick_count_in;
   rles_pkg::color_type current_ff, current_in;
   logic                owned_ff, owned_in;
   logic [SEQ_AW-1:0]   seq_cursor_ff, seq_cursor_in;
   logic [SEQ_CW-1:0]   seq_count_ff, seq_count_in;
   logic                changed;

   // ---------------------------------------------------------------------
   // Tables.
   // ---------------------------------------------------------------------
   rles_pkg::pal_wr_type pal_wr;
   rles_pkg::seq_wr_type seq_wr;
   logic [3:0]           pal_rd_pnum  [rles_pkg::PAL_RD_PORTS];
   rles_pkg::color_type  pal_rd_color [rles_pkg::PAL_RD_PORTS];
   logic [SEQ_AW-1:0]    seq_rd_pos   [rles_pkg::SEQ_RD_PORTS];
   logic [3:0]           seq_rd_value [rles_pkg::SEQ_RD_PORTS];

   logic [SEQ_AW:0]      cursor_plus;
   logic                 cursor_wrap;
   logic [SEQ_AW-1:0]    next_cursor;

   // Advancing the cursor wraps to 0 at the sequence length or the depth.
   // A stale cursor past a shortened length wraps on its next advance.
   assign cursor_plus = {1'b0, seq_cursor_ff} + 1'b1;
   assign cursor_wrap = (32'(cursor_plus) >= 32'(seq_count_ff)) ||
                        (32'(cursor_plus) >= SEQ_DEPTH);
   assign next_cursor = cursor_wrap ? '0 : cursor_plus[SEQ_AW-1:0];

   assign seq_rd_pos[rles_pkg::SRD_CUR]   = seq_cursor_ff;
   assign seq_rd_pos[rles_pkg::SRD_NEXT]  = next_cursor;
   assign seq_rd_pos[rles_pkg::SRD_FIRST] = '0;

   assign pal_rd_pnum[rles_pkg::PRD_CUR]    = seq_rd_value[rles_pkg::SRD_CUR];
   assign pal_rd_pnum[rles_pkg::PRD_NEXT]   = seq_rd_value[rles_pkg::SRD_NEXT];
   assign pal_rd_pnum[rles_pkg::PRD_FIRST]  = seq_rd_value[rles_pkg::SRD_FIRST];
   assign pal_rd_pnum[rles_pkg::PRD_SWAP_A] = hold_pi_ff;
   assign pal_rd_pnum[rles_pkg::PRD_SWAP_B] = hold_si_ff;

   rles_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr       (pal_wr),
      .rd_pnum  (pal_rd_pnum),
      .rd_color (pal_rd_color)
   );

   rles_sequence #(
      .SEQ_DEPTH (SEQ_DEPTH),
      .SEQ_AW    (SEQ_AW)
   ) u_sequence (
      .clock    (clock),
      .reset    (reset),
      .wr       (seq_wr),
      .rd_pos   (seq_rd_pos),
      .rd_value (seq_rd_value)
   );

   // ---------------------------------------------------------------------
   // Compute stage. Everything below is one pass of short logic: decode,
   // table lookups, one compare-and-step per channel.
   // ---------------------------------------------------------------------
   rles_pkg::color_type tgt_cur, tgt_next, tgt_first;
   logic                reached;
   logic [16:0]         tick_bumped;
   logic                step_due;
   logic [SEQ_CW-1:0]   len_sat;
   logic                pi_ok, si_ok;

   assign tgt_cur   = pal_rd_color[rles_pkg::PRD_CUR];
   assign tgt_next  = pal_rd_color[rles_pkg::PRD_NEXT];
   assign tgt_first = pal_rd_color[rles_pkg::PRD_FIRST];
   assign reached   = (current_ff == tgt_cur);

   // The millisecond count saturates, and an effect step runs once it
   // exceeds the configured delay.
   assign tick_bumped = (tick_count_ff != rles_pkg::TICK_MAX) ?
                        tick_count_ff + 17'd1 : tick_count_ff;
   assign step_due    = tick_bumped > {1'b0, delay_ms_ff};

   // A start length saturates at the depth, and zero counts as one.
   always_comb begin
      if (32'(hold_len_ff) > SEQ_DEPTH) begin
         len_sat = SEQ_CW'(SEQ_DEPTH);
      end else if (hold_len_ff == 5'd0) begin
         len_sat = SEQ_CW'(1);
      end else begin
         len_sat = SEQ_CW'(hold_len_ff);
      end
   end

   assign pi_ok = 32'(hold_pi_ff) < PALETTE_DEPTH;
   assign si_ok = 32'(hold_si_ff) < PALETTE_DEPTH;

   always_comb begin
      effect_mode_in = effect_mode_ff;
      tick_count_in  = tick_count_ff;
      current_in     = current_ff;
      owned_in       = owned_ff;
      seq_cursor_in  = seq_cursor_ff;
      seq_count_in   = seq_count_ff;
      changed        = 1'b0;
      pal_wr         = '0;
      seq_wr         = '0;

      case (hold_cmd_ff)
         rles_pkg::CMD_TICK: begin
            tick_count_in = tick_bumped;
            if (step_due) begin
               tick_count_in = '0;
               case (effect_mode_ff)
                  rles_pkg::MODE_OFF: begin
                     current_in = rles_pkg::COLOR_BLACK;
                     owned_in   = 1'b1;
                     changed    = 1'b1;
                  end
                  rles_pkg::MODE_ON: begin
                     current_in = tgt_first;
                     owned_in   = 1'b1;
                     changed    = 1'b1;
                  end
                  rles_pkg::MODE_BREATH: begin
                     // Advance past a reached target, then step toward the
                     // target now under the cursor.
                     if (reached) begin
                        seq_cursor_in = next_cursor;
                        if (current_ff != tgt_next) begin
                           current_in = rles_pkg::step_color(current_ff, tgt_next,
                                                             step_size_ff);
                           owned_in   = 1'b1;
                           changed    = 1'b1;
                        end
                     end else begin
                        current_in = rles_pkg::step_color(current_ff, tgt_cur,
                                                          step_size_ff);
                        owned_in   = 1'b1;
                        changed    = 1'b1;
                     end
                  end
                  rles_pkg::MODE_FADE: begin
                     // On a wrap the color jumps to entry 0 instead of fading.
                     if (reached && cursor_wrap) begin
                        seq_cursor_in = next_cursor;
                        current_in    = tgt_first;
                        owned_in      = 1'b1;
                        changed       = 1'b1;
                     end else if (reached) begin
                        seq_cursor_in = next_cursor;
                        if (current_ff != tgt_next) begin
                           current_in = rles_pkg::step_color(current_ff, tgt_next,
                                                             step_size_ff);
                           owned_in   = 1'b1;
                           changed    = 1'b1;
                        end
                     end else begin
                        current_in = rles_pkg::step_color(current_ff, tgt_cur,
                                                          step_size_ff);
                        owned_in   = 1'b1;
                        changed    = 1'b1;
                     end
                  end
                  rles_pkg::MODE_BLINK: begin
                     current_in    = tgt_cur;
                     owned_in      = 1'b1;
                     changed       = 1'b1;
                     seq_cursor_in = next_cursor;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rles_pkg::CMD_PAL_WRITE: begin
            pal_wr.en_a    = pi_ok;
            pal_wr.addr_a  = hold_pi_ff;
            pal_wr.color_a = '{red: hold_red_ff, green: hold_green_ff,
                               blue: hold_blue_ff};
         end
         rles_pkg::CMD_SEQ_WRITE: begin
            seq_wr.en    = 32'(hold_pos_ff) < SEQ_DEPTH;
            seq_wr.pos   = hold_pos_ff;
            seq_wr.value = hold_pi_ff;
         end
         rles_pkg::CMD_PAL_SWAP: begin
            pal_wr.en_a    = pi_ok & si_ok;
            pal_wr.addr_a  = hold_pi_ff;
            pal_wr.color_a = pal_rd_color[rles_pkg::PRD_SWAP_B];
            pal_wr.en_b    = pi_ok & si_ok;
            pal_wr.addr_b  = hold_si_ff;
            pal_wr.color_b = pal_rd_color[rles_pkg::PRD_SWAP_A];
         end
         rles_pkg::CMD_START: begin
            case (hold_mode_ff)
               rles_pkg::MODE_OFF: begin
                  effect_mode_in = rles_pkg::MODE_OFF;
               end
               rles_pkg::MODE_ON: begin
                  // The requested color becomes the one-entry sequence.
                  effect_mode_in = rles_pkg::MODE_ON;
                  seq_wr.en      = 1'b1;
                  seq_wr.pos     = 4'd0;
                  seq_wr.value   = hold_pi_ff;
                  seq_count_in   = SEQ_CW'(1);
               end
               rles_pkg::MODE_BREATH: begin
                  effect_mode_in = rles_pkg::MODE_BREATH;
                  seq_count_in   = len_sat;
                  seq_cursor_in  = '0;
               end
               rles_pkg::MODE_FADE: begin
                  effect_mode_in = rles_pkg::MODE_FADE;
                  seq_count_in   = len_sat;
                  seq_cursor_in  = '0;
                  current_in     = tgt_first;
                  owned_in       = 1'b1;
                  changed        = 1'b1;
               end
               rles_pkg::MODE_BLINK: begin
                  effect_mode_in = rles_pkg::MODE_BLINK;
                  seq_count_in   = len_sat;
               end
               rles_pkg::MODE_RELEASED: begin
                  effect_mode_in = rles_pkg::MODE_RELEASED;
                  owned_in       = 1'b0;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      // Table writes only land when the request really completes.
      if (!fire) begin
         pal_wr = '0;
         seq_wr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_mode_ff <= rles_pkg::MODE_OFF;
         tick_count_ff  <= '0;
         current_ff     <= rles_pkg::COLOR_BLACK;
         owned_ff       <= 1'b0;
         seq_cursor_ff  <= '0;
         seq_count_ff   <= SEQ_CW'(1);
      end else if (fire) begin
         effect_mode_ff <= effect_mode_in;
         tick_count_ff  <= tick_count_in;
         current_ff     <= current_in;
         owned_ff       <= owned_in;
         seq_cursor_ff  <= seq_cursor_in;
         seq_count_ff   <= seq_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register. It is loaded by the compute stage and emptied by
   // the consumer; a full register stalls the compute stage and, through it, the input register.
   // ---------------------------------------------------------------------
   logic [7:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic       rsp_owned_ff, rsp_changed_ff;

   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_red_ff     <= current_in.red;
         rsp_green_ff   <= current_in.green;
         rsp_blue_ff    <= current_in.blue;
         rsp_owned_ff   <= owned_in;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_out       = rsp_red_ff;
   assign rsp_green_out     = rsp_green_ff;
   assign rsp_blue_out      = rsp_blue_ff;
   assign rsp_led_owned     = rsp_owned_ff;
   assign rsp_color_changed = rsp_changed_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // A held request is never dropped while the response side is stalled.
   `RLES_ASSERT(a_hold_kept, clock, reset,
      !(hold_valid_ff && !fire) || (hold_valid_in && !req_take),
      "held request lost or overwritten")
   // Setting a color always claims the LED.
   `RLES_ASSERT(a_changed_owned, clock, reset,
      !(rsp_valid_ff && rsp_color_changed) || rsp_led_owned,
      "color changed without owning the LED")
   // The drive level moves only when a request reports a color change.
   `RLES_ASSERT(a_color_stable, clock, reset,
      (fire && changed) || (current_in == current_ff) || !fire,
      "drive level moved without a color change")
   // A release start hands the LED back in its response.
   `RLES_ASSERT(a_release, clock, reset,
      !(fire && hold_cmd_ff == rles_pkg::CMD_START &&
        hold_mode_ff == rles_pkg::MODE_RELEASED) || !owned_in,
      "release start kept ownership")
   // Cursor and length stay inside the sequence.
   `RLES_ASSERT(a_seq_bounds, clock, reset,
      (32'(seq_cursor_ff) < SEQ_DEPTH) && (seq_count_ff != '0) &&
      (32'(seq_count_ff) <= SEQ_DEPTH),
      "sequence cursor or length out of range")

endmodule

[design/rles_palette.sv]
// Palette register file of the LED effect sequencer: two write ports for
// writes and swaps, several combinational read ports. Depends on rles_pkg.
module rles_palette #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rles_pkg::pal_wr_type  wr,
   input  logic [3:0]            rd_pnum [rles_pkg::PAL_RD_PORTS],
   output rles_pkg::color_type   rd_color [rles_pkg::PAL_RD_PORTS]
);

   localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   rles_pkg::color_type pal_ff [PALETTE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_DEPTH; i++) begin
            pal_ff[i] <= (i == 0) ? rles_pkg::COLOR_WHITE : rles_pkg::COLOR_BLACK;
         end
      end else begin
         if (wr.en_a) begin
            pal_ff[PAL_AW'(wr.addr_a)] <= wr.color_a;
         end
         if (wr.en_b) begin
            pal_ff[PAL_AW'(wr.addr_b)] <= wr.color_b;
         end
      end
   end

   // A palette number beyond the depth reads as black.
   always_comb begin
      for (int p = 0; p < rles_pkg::PAL_RD_PORTS; p++) begin
         if (32'(rd_pnum[p]) < PALETTE_DEPTH) begin
            rd_color[p] = pal_ff[PAL_AW'(rd_pnum[p])];
         end else begin
            rd_color[p] = rles_pkg::COLOR_BLACK;
         end
      end
   end

endmodule

[design/rles_sequence.sv]
// Color sequence register file: one write port, combinational reads at the
// cursor, the next cursor and entry 0. Depends on rles_pkg.
module rles_sequence #(
   parameter int SEQ_DEPTH = 16,
   parameter int SEQ_AW    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rles_pkg::seq_wr_type wr,
   input  logic [SEQ_AW-1:0]    rd_pos [rles_pkg::SEQ_RD_PORTS],
   output logic [3:0]           rd_value [rles_pkg::SEQ_RD_PORTS]
);

   logic [3:0] seq_ff [SEQ_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEQ_DEPTH; i++) begin
            seq_ff[i] <= 4'd0;
         end
      end else if (wr.en) begin
         seq_ff[SEQ_AW'(wr.pos)] <= wr.value;
      end
   end

   always_comb begin
      for (int p = 0; p < rles_pkg::SEQ_RD_PORTS; p++) begin
         rd_value[p] = seq_ff[rd_pos[p]];
      end
   end

endmodule

[test/tb_rgb_led_effect_sequencer_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rgb_led_effect_sequencer_core: it sends LED requests, predicts
// every response with its own model of the sequencer and checks each response field by field.
// Depends on rles_pkg for the command, mode, register and color definitions.
module tb_rgb_led_effect_sequencer_core;

   localparam int PAL_ENTRIES    = 16;
   localparam int SEQ_ENTRIES    = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_GOAL    = 2000;
   localparam int MAX_REPORTS    = 50;

   // Command and mode codes that the block must ignore.
   localparam logic [2:0] CMD_UNKNOWN_FIRST  = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_LAST   = 3'd7;
   localparam logic [2:0] MODE_UNKNOWN_FIRST = 3'd6;
   localparam logic [2:0] MODE_UNKNOWN_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]          cmd;
      logic [3:0]          pal_idx;
      logic [3:0]          other_idx;
      rles_pkg::color_type color;
      logic [3:0]          slot;
      logic [2:0]          mode;
      logic [4:0]          length;
   } led_request_type;

   typedef struct packed {
      rles_pkg::color_type color;
      logic                owned;
      logic                changed;
   } led_output_type;

   // Clock, reset and the three channels of the block.
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_cmd;
   logic [3:0]  req_palette_index;
   logic [3:0]  req_second_index;
   logic [7:0]  req_red_in;
   logic [7:0]  req_green_in;
   logic [7:0]  req_blue_in;
   logic [3:0]  req_seq_position;
   logic [2:0]  req_mode_in;
   logic [4:0]  req_seq_length;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_led_owned;
   logic        rsp_color_changed;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   // Shadow state of the sequencer, updated in request order.
   rles_pkg::color_type palette_rgb [PAL_ENTRIES];
   logic [3:0]          sequence_slots [SEQ_ENTRIES];
   rles_pkg::mode_type  active_mode;
   logic [16:0]         ms_ticks;
   rles_pkg::color_type shown_color;
   logic                shown_owned;
   logic                shown_changed;
   logic [3:0]          cursor_pos;
   logic [4:0]          active_length;
   logic [7:0]          fade_step;
   logic [15:0]         step_delay;

   // Responses still owed by the block, oldest first.
   led_output_type pending_outputs [$];

   int sender_idle_pct;
   int receiver_stall_pct;
   int error_count;
   int requests_sent;
   int effective_requests;
   int responses_checked;
   int color_updates;
   int config_writes;
   int quiet_cycles;

   rgb_led_effect_sequencer_core #(
      .PALETTE_DEPTH(PAL_ENTRIES),
      .SEQ_DEPTH    (SEQ_ENTRIES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_palette_index(req_palette_index),
      .req_second_index (req_second_index),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_seq_position (req_seq_position),
      .req_mode_in      (req_mode_in),
      .req_seq_length   (req_seq_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_led_owned    (rsp_led_owned),
      .rsp_color_changed(rsp_color_changed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Sequencer prediction
   // ------------------------------------------------------------------

   function automatic void reset_sequencer_state();
      foreach (palette_rgb[i]) palette_rgb[i] = rles_pkg::COLOR_BLACK;
      palette_rgb[0] = rles_pkg::COLOR_WHITE;
      foreach (sequence_slots[i]) sequence_slots[i] = '0;
      active_mode   = rles_pkg::MODE_OFF;
      ms_ticks      = '0;
      shown_color   = rles_pkg::COLOR_BLACK;
      shown_owned   = 1'b0;
      shown_changed = 1'b0;
      cursor_pos    = '0;
      active_length = 5'd1;
      fade_step     = rles_pkg::STEP_SIZE_RESET;
      step_delay    = rles_pkg::DELAY_MS_RESET;
   endfunction

   // Palette color named by one sequence slot.
   function automatic rles_pkg::color_type slot_color(input logic [3:0] slot);
      return palette_rgb[sequence_slots[slot]];
   endfunction

   // Any color that is set also claims the LED.
   function automatic void show_color(input rles_pkg::color_type c);
      shown_color   = c;
      shown_owned   = 1'b1;
      shown_changed = 1'b1;
   endfunction

   function automatic logic [7:0] nudge_channel(input logic [7:0] cur, input logic [7:0] tgt);
      if (cur >= tgt) return (cur - tgt <= fade_step) ? tgt : cur - fade_step;
      return (tgt - cur <= fade_step) ? tgt : cur + fade_step;
   endfunction

   // One fade step toward a slot's color. The color counts as set even when a zero step
   // leaves every channel where it was; only an exact match skips the update.
   function automatic void fade_toward(input logic [3:0] slot);
      rles_pkg::color_type tgt;
      rles_pkg::color_type nxt;
      tgt = slot_color(slot);
      if (tgt != shown_color) begin
         nxt.red   = nudge_channel(shown_color.red, tgt.red);
         nxt.green = nudge_channel(shown_color.green, tgt.green);
         nxt.blue  = nudge_channel(shown_color.blue, tgt.blue);
         show_color(nxt);
      end
   endfunction

   // Moves the cursor on and reports whether it wrapped to slot 0.
   function automatic logic advance_cursor();
      int nxt;
      nxt = cursor_pos + 1;
      if (nxt >= active_length || nxt >= SEQ_ENTRIES) begin
         cursor_pos = '0;
         return 1'b1;
      end
      cursor_pos = 4'(nxt);
      return 1'b0;
   endfunction

   function automatic void run_effect_step();
      case (active_mode)
         rles_pkg::MODE_OFF: show_color(rles_pkg::COLOR_BLACK);
         rles_pkg::MODE_ON:  show_color(slot_color(4'd0));
         rles_pkg::MODE_BREATH: begin
            if (slot_color(cursor_pos) == shown_color) void'(advance_cursor());
            fade_toward(cursor_pos);
         end
         rles_pkg::MODE_FADE: begin
            // On a wrap the fade jumps straight to the first slot's color.
            if (slot_color(cursor_pos) == shown_color) begin
               if (advance_cursor()) show_color(slot_color(4'd0));
            end
            fade_toward(cursor_pos);
         end
         rles_pkg::MODE_BLINK: begin
            show_color(slot_color(cursor_pos));
            void'(advance_cursor());
         end
         default: ;
      endcase
   endfunction

   function automatic led_output_type predict_led_output(input led_request_type rq);
      logic [4:0]          len;
      rles_pkg::color_type held;
      shown_changed = 1'b0;
      case (rq.cmd)
         rles_pkg::CMD_TICK: begin
            if (ms_ticks != rles_pkg::TICK_MAX) ms_ticks = ms_ticks + 1'b1;
            if (ms_ticks > step_delay) begin
               ms_ticks = '0;
               run_effect_step();
            end
         end
         rles_pkg::CMD_PAL_WRITE: palette_rgb[rq.pal_idx] = rq.color;
         rles_pkg::CMD_SEQ_WRITE: sequence_slots[rq.slot] = rq.pal_idx;
         rles_pkg::CMD_PAL_SWAP: begin
            held                      = palette_rgb[rq.pal_idx];
            palette_rgb[rq.pal_idx]   = palette_rgb[rq.other_idx];
            palette_rgb[rq.other_idx] = held;
         end
         rles_pkg::CMD_START: begin
            // Lengths above the sequence depth saturate and zero counts as one.
            len = (rq.length > SEQ_ENTRIES) ? 5'(SEQ_ENTRIES) : rq.length;
            if (len == '0) len = 5'd1;
            case (rq.mode)
               rles_pkg::MODE_OFF: active_mode = rles_pkg::MODE_OFF;
               rles_pkg::MODE_ON: begin
                  active_mode       = rles_pkg::MODE_ON;
                  sequence_slots[0] = rq.pal_idx;
                  active_length     = 5'd1;
               end
               rles_pkg::MODE_BREATH: begin
                  active_mode   = rles_pkg::MODE_BREATH;
                  active_length = len;
                  cursor_pos    = '0;
               end
               rles_pkg::MODE_FADE: begin
                  active_mode   = rles_pkg::MODE_FADE;
                  active_length = len;
                  cursor_pos    = '0;
                  show_color(slot_color(4'd0));
               end
               rles_pkg::MODE_BLINK: begin
                  // Blink keeps a possibly stale cursor; it wraps after one more step.
                  active_mode   = rles_pkg::MODE_BLINK;
                  active_length = len;
               end
               rles_pkg::MODE_RELEASED: begin
                  active_mode = rles_pkg::MODE_RELEASED;
                  shown_owned = 1'b0;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return '{color: shown_color, owned: shown_owned, changed: shown_changed};
   endfunction

   // ------------------------------------------------------------------
   // Request channel
   // ------------------------------------------------------------------

   // A request of the given command whose other fields are all random.
   function automatic led_request_type request_of(input logic [2:0] cmd);
      led_request_type rq;
      logic [63:0]     bits;
      bits   = {$urandom, $urandom};
      rq     = bits[$bits(led_request_type)-1:0];
      rq.cmd = cmd;
      return rq;
   endfunction

   // Offers one request, optionally after a random gap, and holds it until it is
   // accepted. Valid is left high so that back-to-back requests never drop it.
   task automatic send_request(input led_request_type rq);
      if ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99, 0) < sender_idle_pct);
      end
      req_valid         <= 1'b1;
      req_cmd           <= rq.cmd;
      req_palette_index <= rq.pal_idx;
      req_second_index  <= rq.other_idx;
      req_red_in        <= rq.color.red;
      req_green_in      <= rq.color.green;
      req_blue_in       <= rq.color.blue;
      req_seq_position  <= rq.slot;
      req_mode_in       <= rq.mode;
      req_seq_length    <= rq.length;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_outputs.push_back(predict_led_output(rq));
      requests_sent++;
      if (rq.cmd < CMD_UNKNOWN_FIRST &&
          !(rq.cmd == rles_pkg::CMD_START && rq.mode >= MODE_UNKNOWN_FIRST))
         effective_requests++;
   endtask

   task automatic send_tick();
      send_request(request_of(rles_pkg::CMD_TICK));
   endtask

   task automatic send_start(input logic [2:0] mode, input logic [4:0] len,
                             input logic [3:0] idx);
      led_request_type rq;
      rq         = request_of(rles_pkg::CMD_START);
      rq.mode    = mode;
      rq.length  = len;
      rq.pal_idx = idx;
      send_request(rq);
   endtask

   task automatic send_palette_write(input logic [3:0] idx, input rles_pkg::color_type c);
      led_request_type rq;
      rq         = request_of(rles_pkg::CMD_PAL_WRITE);
      rq.pal_idx = idx;
      rq.color   = c;
      send_request(rq);
   endtask

   task automatic send_sequence_write(input logic [3:0] slot, input logic [3:0] value);
      led_request_type rq;
      rq         = request_of(rles_pkg::CMD_SEQ_WRITE);
      rq.slot    = slot;
      rq.pal_idx = value;
      send_request(rq);
   endtask

   task automatic send_swap(input logic [3:0] a, input logic [3:0] b);
      led_request_type rq;
      rq           = request_of(rles_pkg::CMD_PAL_SWAP);
      rq.pal_idx   = a;
      rq.other_idx = b;
      send_request(rq);
   endtask

   // Holds off the sender until every owed response has come back.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register channel
   // ------------------------------------------------------------------

   task automatic write_register(input logic [0:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (idx == rles_pkg::CSR_STEP_SIZE) fade_step = data[7:0];
      else step_delay = data;
      config_writes++;
   endtask

   // Registers change only once the block has nothing in flight. Every request
   // produces a response, so an empty queue means the pipeline is empty too.
   task automatic program_config(input logic [7:0] step_val, input logic [15:0] delay_val);
      wait_for_responses();
      // The upper byte of a step write is don't-care and gets random bits.
      write_register(rles_pkg::CSR_STEP_SIZE, {8'($urandom), step_val});
      write_register(rles_pkg::CSR_DELAY_MS, delay_val);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response checking and receiver stalls
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         if (error_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      led_output_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: response with none expected, expected nothing, actual %h",
                           $time, {rsp_red_out, rsp_green_out, rsp_blue_out,
                                   rsp_led_owned, rsp_color_changed});
               error_count++;
            end else begin
               want = pending_outputs.pop_front();
               check_field("red_out", want.color.red, rsp_red_out);
               check_field("green_out", want.color.green, rsp_green_out);
               check_field("blue_out", want.color.blue, rsp_blue_out);
               check_field("led_owned", 8'(want.owned), 8'(rsp_led_owned));
               check_field("color_changed", 8'(want.changed), 8'(rsp_color_changed));
               responses_checked++;
               if (want.changed) color_updates++;
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   // Ends a hung run: counts cycles in which no channel completes a handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d responses still owed",
                  $time, pending_outputs.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Default registers: a delay of 30 means two ticks cannot run an effect step.
   task automatic test_reset_defaults();
      send_tick();
      send_tick();
   endtask

   // Palette and sequence commands, mode on, the swap and the ignored codes.
   task automatic test_table_commands();
      led_request_type rq;
      program_config(8'd255, 16'd0);
      send_tick();                           // off shows black and claims the LED
      send_start(rles_pkg::MODE_ON, 5'd0, 4'd0);
      send_tick();                           // reset palette entry 0 is white
      send_palette_write(4'd15, '{red: 8'd255, green: 8'd0, blue: 8'd128});
      send_sequence_write(4'd15, 4'd15);
      send_start(rles_pkg::MODE_ON, 5'd31, 4'd15);
      send_tick();
      send_swap(4'd15, 4'd0);
      send_tick();
      rq = request_of(CMD_UNKNOWN_FIRST);
      send_request(rq);
      rq = request_of(CMD_UNKNOWN_LAST);
      send_request(rq);
      send_start(MODE_UNKNOWN_LAST, 5'd3, 4'd1);
   endtask

   // Breath, fade, blink with a cursor left beyond a shortened length, and release.
   task automatic test_effect_modes();
      send_sequence_write(4'd1, 4'd0);
      send_start(rles_pkg::MODE_BREATH, 5'd0, 4'd0);
      send_tick();
      send_start(rles_pkg::MODE_FADE, 5'd31, 4'd0);
      send_tick();
      send_start(rles_pkg::MODE_BLINK, 5'd4, 4'd0);
      repeat (3) send_tick();
      send_start(rles_pkg::MODE_BLINK, 5'd2, 4'd0);
      repeat (2) send_tick();
      send_start(rles_pkg::MODE_RELEASED, 5'd1, 4'd0);
      send_tick();
   endtask

   // A zero step still counts as setting the color although nothing moves.
   task automatic test_zero_step();
      program_config(8'd0, 16'd0);
      send_palette_write(4'd3, '{red: 8'd10, green: 8'd20, blue: 8'd30});
      send_sequence_write(4'd0, 4'd3);
      send_start(rles_pkg::MODE_BREATH, 5'd1, 4'd0);
      send_tick();
   endtask

   // The largest delay: ticks only count.
   task automatic test_long_delay();
      program_config(8'd1, 16'hFFFF);
      send_tick();
      send_tick();
   endtask

   task automatic program_random_config();
      logic [7:0]  step_val;
      logic [15:0] delay_val;
      case ($urandom_range(5, 0))
         0:       step_val = 8'd1;
         1:       step_val = 8'd255;
         2:       step_val = 8'd0;
         default: step_val = 8'($urandom_range(255, 1));
      endcase
      case ($urandom_range(7, 0))
         0:       delay_val = 16'd0;
         1:       delay_val = 16'hFFFF;
         2:       delay_val = 16'($urandom_range(40, 10));
         default: delay_val = 16'($urandom_range(3, 0));
      endcase
      program_config(step_val, delay_val);
   endtask

   // One well-formed scenario: load some colors, start a mode, then run ticks with a
   // little noise mixed in.
   task automatic run_scenario();
      led_request_type rq;
      repeat ($urandom_range(3, 0))
         send_palette_write(4'($urandom), rles_pkg::color_type'(24'($urandom)));
      repeat ($urandom_range(4, 0)) send_sequence_write(4'($urandom), 4'($urandom));
      if ($urandom_range(3, 0) == 0) send_swap(4'($urandom), 4'($urandom));
      rq = request_of(rles_pkg::CMD_START);
      if ($urandom_range(9, 0) == 0)
         rq.mode = 3'($urandom_range(MODE_UNKNOWN_LAST, MODE_UNKNOWN_FIRST));
      else
         rq.mode = 3'($urandom_range(rles_pkg::MODE_RELEASED, rles_pkg::MODE_OFF));
      send_request(rq);
      repeat ($urandom_range(40, 4)) begin
         if ($urandom_range(19, 0) == 0) send_request(request_of(3'($urandom)));
         else send_tick();
      end
      // Now and then the sender stops until the block has answered everything.
      if ($urandom_range(24, 0) == 0) wait_for_responses();
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int item_goal);
      int first_count;
      int scenarios;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      first_count        = effective_requests;
      scenarios          = 0;
      while (effective_requests - first_count < item_goal) begin
         if (scenarios % 4 == 0) program_random_config();
         run_scenario();
         scenarios++;
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cmd            = '0;
      req_palette_index  = '0;
      req_second_index   = '0;
      req_red_in         = '0;
      req_green_in       = '0;
      req_blue_in        = '0;
      req_seq_position   = '0;
      req_mode_in        = '0;
      req_seq_length     = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      sender_idle_pct    = 32;
      receiver_stall_pct = 56;
      error_count        = 0;
      requests_sent      = 0;
      effective_requests = 0;
      responses_checked  = 0;
      color_updates      = 0;
      config_writes      = 0;
      quiet_cycles       = 0;
      reset_sequencer_state();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_table_commands();
      test_effect_modes();
      test_zero_step();
      test_long_delay();

      // Random traffic under three idle profiles: sender gaps with heavy receiver
      // stalls, the reverse, and finally full rate on both sides.
      test_random_traffic(32, 56, RANDOM_GOAL / 3);
      test_random_traffic(56, 32, RANDOM_GOAL / 3);
      test_random_traffic(0, 0, RANDOM_GOAL - 2 * (RANDOM_GOAL / 3));

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d requests (%0d not ignored) under three idle profiles, %0d register writes.",
               requests_sent, effective_requests, config_writes);
      $display("Summary: %0d responses checked, %0d of them set the LED color, %0d mismatches.",
               responses_checked, color_updates, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
